### rtl/core/crq_pkg.sv
package crq_pkg;

   // Field widths of the request and response beats
   localparam int SOUND_ID_W = 10;
   localparam int VOLUME_W   = 9;
   localparam int STATUS_W   = 3;
   localparam int LEVEL_W    = 8;
   localparam int COUNT_W    = 4;

   // Defaults of the top level parameters
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int KEY_BITS_DEF    = 10;

   // Full volume in 1.8 fixed point
   localparam logic [VOLUME_W-1:0] FULL_VOLUME = VOLUME_W'(256);

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_REG_MUTE = '0;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_QUEUED = 3'd0,
      ST_MERGED = 3'd1,
      ST_MUTED  = 3'd2,
      ST_FULL   = 3'd3,
      ST_POPPED = 3'd4,
      ST_EMPTY  = 3'd5
   } status_type;

   // Clamp a requested volume to full volume
   function automatic logic [VOLUME_W-1:0] sat_volume(input logic [VOLUME_W-1:0] v);
      sat_volume = (v > FULL_VOLUME) ? FULL_VOLUME : v;
   endfunction

   // Mixer level: volume * 128 / 256, truncated
   function automatic logic [LEVEL_W-1:0] mixer_level(input logic [VOLUME_W-1:0] v);
      mixer_level = v[VOLUME_W-1:1];
   endfunction

endpackage

### rtl/core/crq_ram.sv
module crq_ram import crq_pkg::*; #(
   parameter int WIDTH = 20,
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/crq_csr.sv
module crq_csr import crq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic                  mute
);

   logic mute_ff;
   logic mute_in;
   logic wr_hit;
   logic [CSR_ADDR_W-3:0] word_idx;

   assign csr_pready = 1'b1;
   assign word_idx   = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (word_idx == CSR_REG_MUTE);

   always_comb begin
      mute_in = mute_ff;
      if (wr_hit) begin
         mute_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_ff <= 1'b0;
      end else begin
         mute_ff <= mute_in;
      end
   end

   // Decode reads; unmapped words read as zero
   always_comb begin
      csr_prdata = '0;
      if (word_idx == CSR_REG_MUTE) begin
         csr_prdata = CSR_DATA_W'(mute_ff);
      end
   end

   assign mute = mute_ff;

endmodule

### rtl/core/coalescing_request_queue_core.sv
// Coalescing play request queue. A push beat (operation 0) carries a sound id, a
// volume (fixed point, 256 is full volume, clamped to 256) and a music flag; it is
// dropped while the mute register is set, merges into a pending entry with the same id
// (which keeps the larger volume and its own music flag), or is appended at the tail,
// or dropped as full when QUEUE_DEPTH-1 entries are pending. A pop beat (operation 1)
// removes the oldest entry and returns its id, volume, mixer level (volume / 2) and
// flag, or reports empty. Every request beat yields exactly one response beat, which
// also carries the number of entries pending afterwards. The entries live in a
// synchronous RAM with one read and one write port, so a push compares one pending
// entry per cycle. One request is handled at a time; a finished response waits in the
// output register and the next request is taken once it is loaded there.
// The mute register lies at byte address 0 of the register port.
module coalescing_request_queue_core import crq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int KEY_BITS    = KEY_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  logic [SOUND_ID_W-1:0] req_sound_id,
   input  logic [VOLUME_W-1:0]   req_volume,
   input  logic                  req_is_music,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SOUND_ID_W-1:0] rsp_out_sound,
   output logic [VOLUME_W-1:0]   rsp_out_volume,
   output logic [LEVEL_W-1:0]    rsp_out_level,
   output logic                  rsp_out_music,
   output logic [COUNT_W-1:0]    rsp_pending_count,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Merge key is the low KEY_BITS of the id, never wider than the id itself
   localparam int KEY_W   = (KEY_BITS < SOUND_ID_W) ? KEY_BITS : SOUND_ID_W;
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int ENTRY_W = KEY_W + VOLUME_W + 1;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_POP,
      S_DONE
   } state_type;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
   endfunction

   logic mute;

   crq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mute        (mute)
   );

   // Entry RAM: {key, volume, music}
   logic               ram_we;
   logic [PTR_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic               ram_re;
   logic [PTR_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   crq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic [KEY_W-1:0]    rd_key;
   logic [VOLUME_W-1:0] rd_vol;
   logic                rd_mus;

   assign rd_key = ram_rdata[ENTRY_W-1 -: KEY_W];
   assign rd_vol = ram_rdata[VOLUME_W:1];
   assign rd_mus = ram_rdata[0];

   // Control state
   state_type        state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] count_ff, count_in;

   // Scan pipeline: one read issued per cycle, compared in the cycle after
   logic [PTR_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic [PTR_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             rd_last_ff, rd_last_in;

   // Latched request
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VOLUME_W-1:0] vol_ff, vol_in;
   logic                mus_ff, mus_in;

   // Finished result waiting for the output register
   status_type          res_status_ff, res_status_in;
   logic [KEY_W-1:0]    res_sound_ff, res_sound_in;
   logic [VOLUME_W-1:0] res_volume_ff, res_volume_in;
   logic                res_music_ff, res_music_in;
   logic [PTR_W-1:0]    res_count_ff, res_count_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]    rsp_sound_ff, rsp_sound_in;
   logic [VOLUME_W-1:0] rsp_volume_ff, rsp_volume_in;
   logic [LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic                rsp_music_ff, rsp_music_in;
   logic [PTR_W-1:0]    rsp_count_ff, rsp_count_in;

   logic hit;
   logic issue;
   logic scan_end;

   assign req_ready = (state_ff == S_IDLE);
   assign hit       = rd_vld_ff && (rd_key == key_ff);
   assign issue     = (issue_cnt_ff != count_ff) && !hit;
   // No match found: the last entry compared without a hit, or nothing was pending
   assign scan_end  = rd_vld_ff ? (!hit && rd_last_ff) : (count_ff == '0);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      scan_ptr_in   = scan_ptr_ff;
      issue_cnt_in  = issue_cnt_ff;
      rd_vld_in     = 1'b0;
      rd_ptr_in     = rd_ptr_ff;
      rd_last_in    = rd_last_ff;
      key_in        = key_ff;
      vol_in        = vol_ff;
      mus_in        = mus_ff;
      res_status_in = res_status_ff;
      res_sound_in  = res_sound_ff;
      res_volume_in = res_volume_ff;
      res_music_in  = res_music_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sound_in  = rsp_sound_ff;
      rsp_volume_in = rsp_volume_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_music_in  = rsp_music_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = tail_ff;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = head_ff;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in        = req_sound_id[KEY_W-1:0];
               vol_in        = sat_volume(req_volume);
               mus_in        = req_is_music;
               res_sound_in  = '0;
               res_volume_in = '0;
               res_music_in  = 1'b0;
               res_count_in  = count_ff;
               if (req_operation == OP_POP) begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     ram_re   = 1'b1;
                     state_in = S_POP;
                  end
               end else if (mute) begin
                  res_status_in = ST_MUTED;
                  state_in      = S_DONE;
               end else begin
                  scan_ptr_in  = head_ff;
                  issue_cnt_in = '0;
                  state_in     = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (issue) begin
               ram_re       = 1'b1;
               ram_raddr    = scan_ptr_ff;
               rd_vld_in    = 1'b1;
               rd_ptr_in    = scan_ptr_ff;
               rd_last_in   = (issue_cnt_ff == count_ff - PTR_W'(1));
               issue_cnt_in = issue_cnt_ff + PTR_W'(1);
               scan_ptr_in  = next_slot(scan_ptr_ff);
            end
            if (hit) begin
               // Merge: raise volume, keep stored key and flag
               ram_we        = 1'b1;
               ram_waddr     = rd_ptr_ff;
               ram_wdata     = {rd_key, (vol_ff > rd_vol) ? vol_ff : rd_vol, rd_mus};
               res_status_in = ST_MERGED;
               state_in      = S_DONE;
            end else if (scan_end) begin
               if (count_ff == LAST_SLOT) begin
                  res_status_in = ST_FULL;
               end else begin
                  ram_we        = 1'b1;
                  ram_waddr     = tail_ff;
                  ram_wdata     = {key_ff, vol_ff, mus_ff};
                  tail_in       = next_slot(tail_ff);
                  count_in      = count_ff + PTR_W'(1);
                  res_count_in  = count_ff + PTR_W'(1);
                  res_status_in = ST_QUEUED;
               end
               state_in = S_DONE;
            end
         end

         S_POP: begin
            head_in       = next_slot(head_ff);
            count_in      = count_ff - PTR_W'(1);
            res_count_in  = count_ff - PTR_W'(1);
            res_status_in = ST_POPPED;
            res_sound_in  = rd_key;
            res_volume_in = rd_vol;
            res_music_in  = rd_mus;
            state_in      = S_DONE;
         end

         S_DONE: begin
            // Advance into the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_sound_in  = res_sound_ff;
               rsp_volume_in = res_volume_ff;
               rsp_level_in  = mixer_level(res_volume_ff);
               rsp_music_in  = res_music_ff;
               rsp_count_in  = res_count_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         issue_cnt_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ptr_ff   <= scan_ptr_in;
      rd_ptr_ff     <= rd_ptr_in;
      rd_last_ff    <= rd_last_in;
      key_ff        <= key_in;
      vol_ff        <= vol_in;
      mus_ff        <= mus_in;
      res_status_ff <= res_status_in;
      res_sound_ff  <= res_sound_in;
      res_volume_ff <= res_volume_in;
      res_music_ff  <= res_music_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sound_ff  <= rsp_sound_in;
      rsp_volume_ff <= rsp_volume_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_music_ff  <= rsp_music_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_sound     = SOUND_ID_W'(rsp_sound_ff);
   assign rsp_out_volume    = rsp_volume_ff;
   assign rsp_out_level     = rsp_level_ff;
   assign rsp_out_music     = rsp_music_ff;
   assign rsp_pending_count = COUNT_W'(rsp_count_ff);

   // Occupancy implied by the ring pointers
   logic [PTR_W:0] ring_occ;
   assign ring_occ = (tail_ff >= head_ff)
                     ? {1'b0, tail_ff} - {1'b0, head_ff}
                     : {1'b0, tail_ff} + (PTR_W+1)'(QUEUE_DEPTH) - {1'b0, head_ff};

   a_ring_count: assert property (@(posedge clock) disable iff (reset)
      ring_occ == {1'b0, count_ff})
      else $error("ring pointers disagree with entry count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_SLOT)
      else $error("entry count exceeds usable slots");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (issue_cnt_ff <= count_ff))
      else $error("scan issued more reads than pending entries");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in flight");

   a_ram_single_op: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re && (ram_waddr == ram_raddr)))
      else $error("entry read and written in the same cycle");

endmodule

### tb/sv/tb.sv
module tb;
   import crq_pkg::*;

   // Predictor sizing follows the default build of the block
   localparam int SLOTS = QUEUE_DEPTH_DEF;
   localparam logic [SOUND_ID_W-1:0] KEY_MASK = SOUND_ID_W'((1 << KEY_BITS_DEF) - 1);
   localparam logic [VOLUME_W-1:0] LOUDEST = VOLUME_W'(256);
   localparam logic [CSR_ADDR_W-1:0] MUTE_ADDR = {CSR_REG_MUTE, 2'b00};
   localparam int MAX_PRINTED = 30;

   // One request beat as queued for the driver
   typedef struct packed {
      op_type                op;
      logic [SOUND_ID_W-1:0] sound;
      logic [VOLUME_W-1:0]   vol;
      logic                  music;
   } play_request_type;

   // One response beat as the queue should produce it
   typedef struct packed {
      status_type            status;
      logic [SOUND_ID_W-1:0] sound;
      logic [VOLUME_W-1:0]   vol;
      logic [LEVEL_W-1:0]    level;
      logic                  music;
      logic [COUNT_W-1:0]    count;
   } outcome_type;

   logic clock;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_operation = 1'b0;
   logic [SOUND_ID_W-1:0] req_sound_id = '0;
   logic [VOLUME_W-1:0]   req_volume = '0;
   logic                  req_is_music = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SOUND_ID_W-1:0] rsp_out_sound;
   logic [VOLUME_W-1:0]   rsp_out_volume;
   logic [LEVEL_W-1:0]    rsp_out_level;
   logic                  rsp_out_music;
   logic [COUNT_W-1:0]    rsp_pending_count;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   coalescing_request_queue_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_sound_id      (req_sound_id),
      .req_volume        (req_volume),
      .req_is_music      (req_is_music),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_out_sound     (rsp_out_sound),
      .rsp_out_volume    (rsp_out_volume),
      .rsp_out_level     (rsp_out_level),
      .rsp_out_music     (rsp_out_music),
      .rsp_pending_count (rsp_pending_count),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // Request beats waiting to be driven, and response beats still owed
   play_request_type requests_pending[$];
   outcome_type      outcomes_due[$];

   // Predictor copy of the ring and of the mute register
   logic [SOUND_ID_W-1:0] slot_sound[SLOTS];
   logic [VOLUME_W-1:0]   slot_vol[SLOTS];
   logic                  slot_music[SLOTS];
   int                    ring_head = 0;
   int                    ring_tail = 0;
   int                    ring_count = 0;
   bit                    mute_now = 1'b0;

   // Bookkeeping
   bit idle_on = 1'b1;
   int gap_left = 0;
   int stall_left = 0;
   int beats_issued = 0;
   int beats_returned = 0;
   int push_count = 0;
   int pop_count = 0;
   int mute_writes = 0;
   int errors = 0;
   int status_seen[6] = '{default: 0};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Print one line per mismatch (up to a cap) and count every one
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (errors < MAX_PRINTED)
         $display("mismatch: %s after %0d beats, got %0d, want %0d",
                  what, beats_returned, got, want);
      errors++;
   endtask

   // Advance the predictor by one request beat and return the response it owes
   function automatic outcome_type apply_request(op_type op, logic [SOUND_ID_W-1:0] sound,
                                                 logic [VOLUME_W-1:0] vol_in, logic music);
      outcome_type o;
      logic [SOUND_ID_W-1:0] key;
      logic [VOLUME_W-1:0] vol;
      int slot;
      int n;
      bit hit;
      o.status = ST_EMPTY;
      o.sound = '0;
      o.vol = '0;
      o.level = '0;
      o.music = 1'b0;
      key = sound & KEY_MASK;
      vol = (vol_in > LOUDEST) ? LOUDEST : vol_in;
      if (op == OP_PUSH) begin
         if (mute_now) begin
            o.status = ST_MUTED;
         end else begin
            hit = 1'b0;
            slot = ring_head;
            // walk pending entries oldest first; the first match takes the merge
            for (n = 0; n < ring_count && !hit; n++) begin
               if (slot_sound[slot] == key) begin
                  if (vol > slot_vol[slot]) slot_vol[slot] = vol;
                  hit = 1'b1;
               end else begin
                  slot = (slot + 1) % SLOTS;
               end
            end
            if (hit) begin
               o.status = ST_MERGED;
            end else if (ring_count >= SLOTS - 1) begin
               o.status = ST_FULL;
            end else begin
               slot_sound[ring_tail] = key;
               slot_vol[ring_tail] = vol;
               slot_music[ring_tail] = music;
               ring_tail = (ring_tail + 1) % SLOTS;
               ring_count++;
               o.status = ST_QUEUED;
            end
         end
      end else if (ring_count != 0) begin
         o.status = ST_POPPED;
         o.sound = slot_sound[ring_head];
         o.vol = slot_vol[ring_head];
         o.level = LEVEL_W'(slot_vol[ring_head] >> 1);
         o.music = slot_music[ring_head];
         ring_head = (ring_head + 1) % SLOTS;
         ring_count--;
      end
      o.count = COUNT_W'(ring_count);
      return o;
   endfunction

   // Request driver: hold each beat until accepted, predict it at the handshake,
   // then either idle for a short burst or present the next queued beat.
   always @(posedge clock) begin
      play_request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            outcomes_due.push_back(apply_request(op_type'(req_operation), req_sound_id,
                                                 req_volume, req_is_music));
            if (req_operation == OP_PUSH) push_count++;
            else pop_count++;
            if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 4);
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (requests_pending.size() > 0) begin
               nxt = requests_pending.pop_front();
               beats_issued++;
               req_valid <= 1'b1;
               req_operation <= nxt.op;
               req_sound_id <= nxt.sound;
               req_volume <= nxt.vol;
               req_is_music <= nxt.music;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted beat against the oldest outcome owed,
   // and stall the response channel in random bursts while idling is enabled.
   always @(posedge clock) begin
      outcome_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_returned++;
            if (rsp_status < 6) status_seen[rsp_status]++;
            if (outcomes_due.size() == 0) begin
               report_mismatch("response beat with nothing owed", rsp_status, 0);
            end else begin
               due = outcomes_due.pop_front();
               if (rsp_status !== due.status)
                  report_mismatch("status", rsp_status, due.status);
               if (rsp_out_sound !== due.sound)
                  report_mismatch("out_sound", rsp_out_sound, due.sound);
               if (rsp_out_volume !== due.vol)
                  report_mismatch("out_volume", rsp_out_volume, due.vol);
               if (rsp_out_level !== due.level)
                  report_mismatch("out_level", rsp_out_level, due.level);
               if (rsp_out_music !== due.music)
                  report_mismatch("out_music", rsp_out_music, due.music);
               if (rsp_pending_count !== due.count)
                  report_mismatch("pending_count", rsp_pending_count, due.count);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic add_request(op_type op, logic [SOUND_ID_W-1:0] sound,
                              logic [VOLUME_W-1:0] vol, logic music);
      play_request_type r;
      r.op = op;
      r.sound = sound;
      r.vol = vol;
      r.music = music;
      requests_pending.push_back(r);
   endtask

   // Random request: ids mostly from a narrow window so merges and a full ring
   // happen often, sometimes anywhere; volumes sometimes above full scale.
   function automatic play_request_type rand_request(int push_pct, int base, int span);
      play_request_type r;
      r.op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      if ($urandom_range(0, 3) == 0) r.sound = SOUND_ID_W'($urandom_range(0, 1023));
      else r.sound = SOUND_ID_W'(base + $urandom_range(0, span));
      if ($urandom_range(0, 7) == 0) r.vol = VOLUME_W'($urandom_range(257, 511));
      else r.vol = VOLUME_W'($urandom_range(0, 256));
      r.music = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Hold here until every queued beat has been driven and answered
   task automatic wait_drained();
      while (requests_pending.size() != 0 || beats_issued != beats_returned)
         @(posedge clock);
   endtask

   // Write mute through the register port, then read it back
   task automatic set_mute(bit v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= MUTE_ADDR;
      csr_pwdata <= CSR_DATA_W'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      mute_now = v;
      mute_writes++;
      // drop straight into the setup cycle of the read-back
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(v)) report_mismatch("mute read-back", csr_prdata, v);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // One random phase: settle, set mute, queue the beats, drain them
   task automatic run_phase(bit mute_val, int n, int push_pct, int base, int span, bit idle);
      int i;
      wait_drained();
      set_mute(mute_val);
      idle_on = idle;
      for (i = 0; i < n; i++) requests_pending.push_back(rand_request(push_pct, base, span));
      wait_drained();
   endtask

   initial begin
      int i;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_mute(1'b0);

      // Directed: empty pop, field extremes, saturation, merges, full ring
      add_request(OP_POP, 10'd77, 9'd100, 1'b1);
      add_request(OP_PUSH, 10'd0, 9'd0, 1'b0);
      add_request(OP_PUSH, 10'd1023, 9'd256, 1'b1);
      add_request(OP_PUSH, 10'd5, 9'd511, 1'b0);
      // merge raises the volume (clamped) but keeps the stored flag
      add_request(OP_PUSH, 10'd0, 9'd300, 1'b1);
      // merge with a quieter volume leaves the entry alone
      add_request(OP_PUSH, 10'd1023, 9'd10, 1'b0);
      for (i = 0; i < 12; i++)
         add_request(OP_PUSH, SOUND_ID_W'(100 + i), VOLUME_W'(i * 21), i[0]);
      // ring now holds its limit: a new id is dropped, a known id still merges
      add_request(OP_PUSH, 10'd200, 9'd128, 1'b1);
      add_request(OP_PUSH, 10'd5, 9'd1, 1'b1);
      add_request(OP_POP, 10'd0, 9'd0, 1'b0);
      add_request(OP_POP, 10'd1023, 9'd511, 1'b1);
      wait_drained();

      // Muted pushes drop even when they would merge; pops still work
      set_mute(1'b1);
      add_request(OP_PUSH, 10'd5, 9'd200, 1'b0);
      add_request(OP_PUSH, 10'd300, 9'd50, 1'b1);
      add_request(OP_POP, 10'd0, 9'd0, 1'b0);
      wait_drained();

      // Random phases over both mute settings, with and without idling
      run_phase(1'b0, 300, 60, 0, 23, 1'b1);
      run_phase(1'b1, 100, 50, 0, 23, 1'b1);
      run_phase(1'b0, 300, 50, 0, 1023, 1'b0);
      run_phase(1'b0, 250, 70, 1000, 15, 1'b1);
      run_phase(1'b1, 50, 40, 0, 15, 1'b1);
      run_phase(1'b0, 250, 45, 512, 31, 1'b0);

      wait_drained();
      repeat (SLOTS + 4) @(posedge clock);
      $display("covered %0d request beats (%0d push, %0d pop) across %0d mute writes",
               push_count + pop_count, push_count, pop_count, mute_writes);
      $display("queued %0d merged %0d muted %0d full %0d popped %0d empty %0d",
               status_seen[ST_QUEUED], status_seen[ST_MERGED], status_seen[ST_MUTED],
               status_seen[ST_FULL], status_seen[ST_POPPED], status_seen[ST_EMPTY]);
      if (errors == 0 && outcomes_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
rtl/core/crq_pkg.sv
rtl/core/crq_ram.sv
rtl/core/crq_csr.sv
rtl/core/coalescing_request_queue_core.sv
tb/sv/tb.sv
